// ===== src/gtg_pkg.sv =====
// Shared widths, register codes, stage types and the arctangent table.
`timescale 1ns / 1ps

package gtg_pkg;

    // Field widths
    localparam int POS_W      = 14;
    localparam int HEAD_W     = 15;
    localparam int GAIN_W     = 12;
    localparam int TOL_W      = 14;
    localparam int LIN_W      = 15;
    localparam int TURN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Internal widths
    localparam int OFS_W       = POS_W + 1;          // signed goal offset
    localparam int SQ_W        = 2 * POS_W + 2;      // dx^2 + dy^2
    localparam int ROOT_W      = SQ_W / 2;           // floor square root
    localparam int REM_W       = ROOT_W + 3;         // sqrt partial remainder
    localparam int ANG_FRAC    = 16;                 // CORDIC vector scaling
    localparam int CX_W        = OFS_W + ANG_FRAC + 3;
    localparam int CZ_W        = 21;                 // Q16 angle accumulator
    localparam int BEAR_W      = CZ_W + 1 - 4;       // rounded bearing, Q12
    localparam int ERR_W       = BEAR_W + 1;         // bearing minus heading
    localparam int LPROD_W     = GAIN_W + ROOT_W;
    localparam int APROD_W     = GAIN_W + 1 + ERR_W;
    localparam int CORDIC_STAGES = 16;
    localparam int PIPE_STAGES   = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;

    localparam logic signed [CZ_W-1:0] PI_Q16 = CZ_W'(205887);

    // Register reset values
    localparam logic [POS_W-1:0]  GOAL_X_RST   = POS_W'(1024);
    localparam logic [POS_W-1:0]  GOAL_Y_RST   = POS_W'(1024);
    localparam logic [TOL_W-1:0]  STOP_TOL_RST = TOL_W'(10);
    localparam logic [GAIN_W-1:0] LIN_GAIN_RST = GAIN_W'(384);
    localparam logic [GAIN_W-1:0] ANG_GAIN_RST = GAIN_W'(1024);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_X   = 3'd0,
        CFG_GOAL_Y   = 3'd1,
        CFG_STOP_TOL = 3'd2,
        CFG_LIN_GAIN = 3'd3,
        CFG_ANG_GAIN = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]  goal_x;
        logic [POS_W-1:0]  goal_y;
        logic [TOL_W-1:0]  stop_tol;
        logic [GAIN_W-1:0] lin_gain;
        logic [GAIN_W-1:0] ang_gain;
    } cfg_t;

    // State carried through the square root / CORDIC stages
    typedef struct packed {
        logic [SQ_W-1:0]          rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [CZ_W-1:0]   cz;
        logic signed [HEAD_W-1:0] heading;
    } iter_t;

    // round(atan(2^-i) * 65536)
    function automatic logic signed [CZ_W-1:0] atan_q16(input int idx);
        logic signed [CZ_W-1:0] val;
        case (idx)
            0:       val = CZ_W'(51472);
            1:       val = CZ_W'(30386);
            2:       val = CZ_W'(16055);
            3:       val = CZ_W'(8150);
            4:       val = CZ_W'(4091);
            5:       val = CZ_W'(2047);
            6:       val = CZ_W'(1024);
            7:       val = CZ_W'(512);
            8:       val = CZ_W'(256);
            9:       val = CZ_W'(128);
            10:      val = CZ_W'(64);
            11:      val = CZ_W'(32);
            12:      val = CZ_W'(16);
            13:      val = CZ_W'(8);
            14:      val = CZ_W'(4);
            15:      val = CZ_W'(2);
            16:      val = CZ_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/go_to_goal_p_controller_top.sv =====
// Top level of the go-to-goal proportional controller.
`timescale 1ns / 1ps
//
// Pose channel: pose_valid / pose_stall carry pose_x, pose_y (unsigned Q4.10)
// and pose_heading (signed Q3.12 radians); a beat is taken when pose_valid is
// high and pose_stall is low.
// Command channel: cmd_valid / cmd_stall carry linear_speed (unsigned Q5.10), turn_rate
// (signed Q4.12) and goal_reached, one command beat per pose beat, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, unknown indexes are dropped. Write only while the pipe is
// empty.
// Stages from pose beat to command beat: 3 front stages, 16 iterative stages
// (square root and CORDIC in parallel, the CORDIC stage count sets the length)
// and 3 back-end stages including the output register.
// Throughput: one pose beat per cycle while the command side is not stalled.
// When cmd_stall is high with a command waiting, the whole pipe holds and
// pose_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default goal, tolerance and
// gains; no clearing pass is needed.
//
module go_to_goal_p_controller_top
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pose_valid,
    output logic                     pose_stall,
    input  logic [POS_W-1:0]         pose_x,
    input  logic [POS_W-1:0]         pose_y,
    input  logic signed [HEAD_W-1:0] pose_heading,
    output logic                     cmd_valid,
    input  logic                     cmd_stall,
    output logic [LIN_W-1:0]         linear_speed,
    output logic signed [TURN_W-1:0] turn_rate,
    output logic                     goal_reached,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t  cfg_reg;
    logic  adv;
    logic  front_valid;
    iter_t front_data;
    logic  iter_valid;
    iter_t iter_data;

    // pipe advances unless a finished command is held back
    assign adv        = !(cmd_valid && cmd_stall);
    assign pose_stall = !adv;
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x   <= GOAL_X_RST;
            cfg_reg.goal_y   <= GOAL_Y_RST;
            cfg_reg.stop_tol <= STOP_TOL_RST;
            cfg_reg.lin_gain <= LIN_GAIN_RST;
            cfg_reg.ang_gain <= ANG_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GOAL_X:   cfg_reg.goal_x   <= cfg_data[POS_W-1:0];
                CFG_GOAL_Y:   cfg_reg.goal_y   <= cfg_data[POS_W-1:0];
                CFG_STOP_TOL: cfg_reg.stop_tol <= cfg_data[TOL_W-1:0];
                CFG_LIN_GAIN: cfg_reg.lin_gain <= cfg_data[GAIN_W-1:0];
                CFG_ANG_GAIN: cfg_reg.ang_gain <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    gtg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .beat_valid   (pose_valid),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .cfg          (cfg_reg),
        .front_valid  (front_valid),
        .front_data   (front_data)
    );

    gtg_iter u_iter (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .iter_valid_in  (front_valid),
        .iter_in        (front_data),
        .iter_valid_out (iter_valid),
        .iter_out       (iter_data)
    );

    gtg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .back_valid_in  (iter_valid),
        .back_in        (iter_data),
        .cfg            (cfg_reg),
        .back_valid_out (cmd_valid),
        .linear_speed   (linear_speed),
        .turn_rate      (turn_rate),
        .goal_reached   (goal_reached)
    );

`ifndef SYNTHESIS
    // a reached goal always comes with zero commands
    a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && goal_reached) |-> (linear_speed == '0 && turn_rate == '0))
        else $error("goal reached with non-zero command");

    // a held command must back-pressure the pose side
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |-> pose_stall)
        else $error("pose accepted while command held");

    // a held command stays put for the next cycle
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |=> (cmd_valid && $stable(linear_speed)
                                      && $stable(turn_rate) && $stable(goal_reached)))
        else $error("held command changed");
`endif

endmodule

// ===== src/gtg_front.sv =====
// Front end: goal offset, squares, sum and CORDIC half-plane pre-rotation.
`timescale 1ns / 1ps

module gtg_front
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     beat_valid,
    input  logic [POS_W-1:0]         pose_x,
    input  logic [POS_W-1:0]         pose_y,
    input  logic signed [HEAD_W-1:0] pose_heading,
    input  cfg_t                     cfg,
    output logic                     front_valid,
    output iter_t                    front_data
);

    // Stage A: goal offset
    logic                     a_valid_reg;
    logic signed [OFS_W-1:0]  a_dx_reg, a_dy_reg;
    logic signed [HEAD_W-1:0] a_hd_reg;
    logic signed [OFS_W-1:0]  dx_next, dy_next;

    assign dx_next = $signed({1'b0, cfg.goal_x}) - $signed({1'b0, pose_x});
    assign dy_next = $signed({1'b0, cfg.goal_y}) - $signed({1'b0, pose_y});

    // Stage B: squares and pre-rotation
    logic                     b_valid_reg;
    logic [SQ_W-2:0]          b_sqx_reg, b_sqy_reg;
    logic signed [CX_W-1:0]   b_cx_reg, b_cy_reg;
    logic signed [CZ_W-1:0]   b_cz_reg;
    logic signed [HEAD_W-1:0] b_hd_reg;
    logic signed [2*OFS_W-1:0] sqx, sqy;
    logic signed [CX_W-1:0]   x0, y0, cx_next, cy_next;
    logic signed [CZ_W-1:0]   cz_next;

    assign sqx = a_dx_reg * a_dx_reg;
    assign sqy = a_dy_reg * a_dy_reg;
    assign x0  = {{(CX_W-OFS_W-ANG_FRAC){a_dx_reg[OFS_W-1]}}, a_dx_reg, {ANG_FRAC{1'b0}}};
    assign y0  = {{(CX_W-OFS_W-ANG_FRAC){a_dy_reg[OFS_W-1]}}, a_dy_reg, {ANG_FRAC{1'b0}}};

    // left half-plane: turn by pi, +pi on the upper side and on the axis
    always_comb
    begin
        cx_next = x0;
        cy_next = y0;
        cz_next = '0;
        if (a_dx_reg[OFS_W-1])
        begin
            cx_next = -x0;
            cy_next = -y0;
            cz_next = a_dy_reg[OFS_W-1] ? -PI_Q16 : PI_Q16;
        end
    end

    // Stage C: sum of squares
    logic  c_valid_reg;
    iter_t c_data_reg;
    iter_t c_data_next;

    always_comb
    begin
        c_data_next.rad     = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
        c_data_next.rem     = '0;
        c_data_next.root    = '0;
        c_data_next.cx      = b_cx_reg;
        c_data_next.cy      = b_cy_reg;
        c_data_next.cz      = b_cz_reg;
        c_data_next.heading = b_hd_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= beat_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg   <= dx_next;
            a_dy_reg   <= dy_next;
            a_hd_reg   <= pose_heading;
            b_sqx_reg  <= sqx[SQ_W-2:0];
            b_sqy_reg  <= sqy[SQ_W-2:0];
            b_cx_reg   <= cx_next;
            b_cy_reg   <= cy_next;
            b_cz_reg   <= cz_next;
            b_hd_reg   <= a_hd_reg;
            c_data_reg <= c_data_next;
        end
    end

    assign front_valid = c_valid_reg;
    assign front_data  = c_data_reg;

endmodule

// ===== src/gtg_iter.sv =====
// Iterative stages: digit-by-digit square root alongside CORDIC vectoring.
`timescale 1ns / 1ps

module gtg_iter
    import gtg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  iter_valid_in,
    input  iter_t iter_in,
    output logic  iter_valid_out,
    output iter_t iter_out
);

    iter_t                  stage_reg [PIPE_STAGES];
    iter_t                  stage_cur [PIPE_STAGES];
    iter_t                  stage_next [PIPE_STAGES];
    logic [PIPE_STAGES-1:0] valid_reg;

    assign stage_cur[0] = iter_in;

    genvar k;
    generate
        for (k = 0; k < PIPE_STAGES; k++)
        begin : g_stage
            if (k > 0)
            begin : g_link
                assign stage_cur[k] = stage_reg[k-1];
            end

            always_comb
            begin
                logic [REM_W-1:0]       rem_sh;
                logic [REM_W-1:0]       trial;
                logic signed [CX_W-1:0] xs, ys;
                stage_next[k] = stage_cur[k];

                // one root bit per stage
                if (k < ROOT_W)
                begin
                    rem_sh = {stage_cur[k].rem[REM_W-3:0], stage_cur[k].rad[SQ_W-1 -: 2]};
                    trial  = REM_W'({stage_cur[k].root, 2'b01});
                    stage_next[k].rad = {stage_cur[k].rad[SQ_W-3:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        stage_next[k].rem  = rem_sh - trial;
                        stage_next[k].root = {stage_cur[k].root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        stage_next[k].rem  = rem_sh;
                        stage_next[k].root = {stage_cur[k].root[ROOT_W-2:0], 1'b0};
                    end
                end

                // one micro-rotation per stage, driving y to zero
                if (k < CORDIC_STAGES)
                begin
                    xs = stage_cur[k].cx >>> k;
                    ys = stage_cur[k].cy >>> k;
                    if (!stage_cur[k].cy[CX_W-1])
                    begin
                        stage_next[k].cx = stage_cur[k].cx + ys;
                        stage_next[k].cy = stage_cur[k].cy - xs;
                        stage_next[k].cz = stage_cur[k].cz + atan_q16(k);
                    end
                    else
                    begin
                        stage_next[k].cx = stage_cur[k].cx - ys;
                        stage_next[k].cy = stage_cur[k].cy + xs;
                        stage_next[k].cz = stage_cur[k].cz - atan_q16(k);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stage_reg[k] <= stage_next[k];
                end
            end
        end
    endgenerate

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], iter_valid_in};
        end
    end

    assign iter_valid_out = valid_reg[PIPE_STAGES-1];
    assign iter_out       = stage_reg[PIPE_STAGES-1];

endmodule

// ===== src/gtg_back.sv =====
// Back end: tolerance check, gain multiplies, rounding and saturation.
`timescale 1ns / 1ps

module gtg_back
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     back_valid_in,
    input  iter_t                    back_in,
    input  cfg_t                     cfg,
    output logic                     back_valid_out,
    output logic [LIN_W-1:0]         linear_speed,
    output logic signed [TURN_W-1:0] turn_rate,
    output logic                     goal_reached
);

    // Stage D: reach test, linear product, heading error
    logic                    d_valid_reg;
    logic                    d_reached_reg;
    logic [LPROD_W-1:0]      d_lprod_reg;
    logic signed [ERR_W-1:0] d_err_reg;
    logic signed [CZ_W:0]    z_round;
    logic signed [BEAR_W-1:0] bearing;
    logic                    reached_next;
    logic [LPROD_W-1:0]      lprod_next;
    logic signed [ERR_W-1:0] err_next;

    assign reached_next = back_in.root <= {1'b0, cfg.stop_tol};
    assign lprod_next   = LPROD_W'(cfg.lin_gain) * LPROD_W'(back_in.root);
    assign z_round      = {back_in.cz[CZ_W-1], back_in.cz} + (CZ_W+1)'(8);
    assign bearing      = z_round[CZ_W:4];
    assign err_next     = ERR_W'(bearing) - ERR_W'(back_in.heading);

    // Stage E: angular product, linear round and clamp
    logic                      e_valid_reg;
    logic                      e_reached_reg;
    logic [LIN_W-1:0]          e_lin_reg;
    logic signed [APROD_W-1:0] e_aprod_reg;
    logic signed [APROD_W-1:0] aprod_next;
    logic [LPROD_W:0]          lin_sum;
    logic [LPROD_W-8:0]        lin_shift;
    logic [LIN_W-1:0]          lin_next;

    assign aprod_next = $signed({1'b0, cfg.ang_gain}) * d_err_reg;
    assign lin_sum    = {1'b0, d_lprod_reg} + (LPROD_W+1)'(128);
    assign lin_shift  = lin_sum[LPROD_W:8];
    assign lin_next   = (lin_shift > (LPROD_W-7)'({LIN_W{1'b1}})) ? {LIN_W{1'b1}}
                                                                 : lin_shift[LIN_W-1:0];

    // Stage F: angular round and clamp, output register
    logic                     f_valid_reg;
    logic                     f_reached_reg;
    logic [LIN_W-1:0]         f_lin_reg;
    logic signed [TURN_W-1:0] f_turn_reg;
    logic signed [APROD_W:0]  turn_sum;
    logic signed [APROD_W-10:0] turn_shift;
    logic signed [TURN_W-1:0] turn_next;
    localparam logic signed [APROD_W-10:0] TURN_MAX = (APROD_W-9)'(32767);
    localparam logic signed [APROD_W-10:0] TURN_MIN = -(APROD_W-9)'(32768);

    assign turn_sum   = {e_aprod_reg[APROD_W-1], e_aprod_reg} + (APROD_W+1)'(512);
    assign turn_shift = turn_sum[APROD_W:10];

    always_comb
    begin
        if (turn_shift > TURN_MAX)
        begin
            turn_next = TURN_MAX[TURN_W-1:0];
        end
        else if (turn_shift < TURN_MIN)
        begin
            turn_next = TURN_MIN[TURN_W-1:0];
        end
        else
        begin
            turn_next = turn_shift[TURN_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= back_valid_in;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    // payload; commands forced to zero once the goal is reached
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reached_reg <= reached_next;
            d_lprod_reg   <= lprod_next;
            d_err_reg     <= err_next;
            e_reached_reg <= d_reached_reg;
            e_lin_reg     <= lin_next;
            e_aprod_reg   <= aprod_next;
            f_reached_reg <= e_reached_reg;
            f_lin_reg     <= e_reached_reg ? '0 : e_lin_reg;
            f_turn_reg    <= e_reached_reg ? '0 : turn_next;
        end
    end

    assign back_valid_out = f_valid_reg;
    assign linear_speed   = f_lin_reg;
    assign turn_rate      = f_turn_reg;
    assign goal_reached   = f_reached_reg;

endmodule

// ===== tb/go_to_goal_p_controller_checker.sv =====
// Checker for the go-to-goal controller: follows the register writes, predicts each command beat.
`timescale 1ns / 1ps

module go_to_goal_p_controller_checker
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pose_valid,
    input  logic                     pose_stall,
    input  logic [POS_W-1:0]         pose_x,
    input  logic [POS_W-1:0]         pose_y,
    input  logic signed [HEAD_W-1:0] pose_heading,
    input  logic                     cmd_valid,
    input  logic                     cmd_stall,
    input  logic [LIN_W-1:0]         linear_speed,
    input  logic signed [TURN_W-1:0] turn_rate,
    input  logic                     goal_reached,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       pending_cmds,
    output int                       mismatches
);

    typedef struct packed {
        logic [LIN_W-1:0]         lin;
        logic signed [TURN_W-1:0] turn;
        logic                     reached;
    } command_t;

    localparam longint HALF_TURN_Q16 = 205887;
    localparam longint LIN_MAX       = 2 ** LIN_W - 1;
    localparam longint TURN_MAX      = 2 ** (TURN_W - 1) - 1;
    localparam longint TURN_MIN      = -(2 ** (TURN_W - 1));

    cfg_t     ctl;
    command_t cmd_q[$];

    // floor of the square root, one result bit at a time
    function automatic longint floor_sqrt(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // atan2(dy, dx) in Q3.12 by CORDIC vectoring on Q16 scaled offsets
    function automatic longint bearing_q12(input longint dx, input longint dy);
        longint x, y, z, xs, ys, step;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        // left half plane: turn the vector through pi first
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs   = x >>> i;
            ys   = y >>> i;
            step = longint'($floor($atan(2.0 ** (-i)) * 65536.0 + 0.5));
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step;
            end
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic command_t predict_command(input logic [POS_W-1:0]         px,
                                                 input logic [POS_W-1:0]         py,
                                                 input logic signed [HEAD_W-1:0] hd);
        longint   dx, dy, radius, lin, turn;
        command_t c;
        dx     = longint'(ctl.goal_x) - longint'(px);
        dy     = longint'(ctl.goal_y) - longint'(py);
        radius = floor_sqrt(dx * dx + dy * dy);
        c.reached = 1'b0;
        // inside the tolerance both commands are held at zero
        if (radius <= longint'(ctl.stop_tol))
        begin
            c.lin     = '0;
            c.turn    = '0;
            c.reached = 1'b1;
            return c;
        end
        lin = (longint'(ctl.lin_gain) * radius + 128) >>> 8;
        if (lin > LIN_MAX)
            lin = LIN_MAX;
        turn = (longint'(ctl.ang_gain) * (bearing_q12(dx, dy) - longint'(hd)) + 512) >>> 10;
        if (turn > TURN_MAX)
            turn = TURN_MAX;
        if (turn < TURN_MIN)
            turn = TURN_MIN;
        c.lin  = LIN_W'(lin);
        c.turn = TURN_W'(turn);
        return c;
    endfunction

    task automatic log_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] command mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Register copy, prediction on pose beats, comparison on command beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        command_t want;
        if (!rst_n)
        begin
            ctl.goal_x   <= GOAL_X_RST;
            ctl.goal_y   <= GOAL_Y_RST;
            ctl.stop_tol <= STOP_TOL_RST;
            ctl.lin_gain <= LIN_GAIN_RST;
            ctl.ang_gain <= ANG_GAIN_RST;
            cmd_q.delete();
            pending_cmds <= 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GOAL_X:   ctl.goal_x   <= cfg_data[POS_W-1:0];
                    CFG_GOAL_Y:   ctl.goal_y   <= cfg_data[POS_W-1:0];
                    CFG_STOP_TOL: ctl.stop_tol <= cfg_data[TOL_W-1:0];
                    CFG_LIN_GAIN: ctl.lin_gain <= cfg_data[GAIN_W-1:0];
                    CFG_ANG_GAIN: ctl.ang_gain <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (pose_valid && !pose_stall)
                cmd_q.push_back(predict_command(pose_x, pose_y, pose_heading));
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_q.size() == 0)
                    log_mismatch("unexpected beat, linear_speed", linear_speed, 0);
                else
                begin
                    want = cmd_q.pop_front();
                    if (linear_speed !== want.lin)
                        log_mismatch("linear_speed", linear_speed, want.lin);
                    if (turn_rate !== want.turn)
                        log_mismatch("turn_rate", longint'(turn_rate),
                                     longint'(signed'(want.turn)));
                    if (goal_reached !== want.reached)
                        log_mismatch("goal_reached", goal_reached, want.reached);
                end
            end
            pending_cmds <= cmd_q.size();
        end
    end

endmodule

// ===== tb/go_to_goal_p_controller_top_tb.sv =====
// Testbench top for the go-to-goal controller: clock, reset, pose and register stimulus, verdict.
`timescale 1ns / 1ps

module go_to_goal_p_controller_top_tb;
    import gtg_pkg::*;

    localparam int POS_MAX       = 2 ** POS_W - 1;
    localparam int TOL_MAX       = 2 ** TOL_W - 1;
    localparam int GAIN_MAX      = 2 ** GAIN_W - 1;
    localparam int HEAD_MIN      = -(2 ** (HEAD_W - 1));
    localparam int HEAD_MAX      = 2 ** (HEAD_W - 1) - 1;
    localparam int HEADING_PI    = 12868;
    localparam int PHASES        = 9;
    localparam int BEATS_PER_PHASE = 150;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     pose_valid   = 1'b0;
    logic [POS_W-1:0]         pose_x       = '0;
    logic [POS_W-1:0]         pose_y       = '0;
    logic signed [HEAD_W-1:0] pose_heading = '0;
    logic                     cmd_stall    = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [CFG_DATA_W-1:0]    cfg_data     = '0;
    logic                     pose_stall;
    logic                     cmd_valid;
    logic [LIN_W-1:0]         linear_speed;
    logic signed [TURN_W-1:0] turn_rate;
    logic                     goal_reached;
    logic                     cfg_ready;
    int                       pending_cmds;
    int                       mismatches;

    int gap_max     = 9;
    int stall_max   = 9;
    int cycle_count = 0;
    int goal_x_now  = GOAL_X_RST;
    int goal_y_now  = GOAL_Y_RST;
    int tol_now     = STOP_TOL_RST;

    go_to_goal_p_controller_top dut (.*);

    go_to_goal_p_controller_checker u_checker (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("go_to_goal_p_controller_top_tb NOT OK");
            $finish;
        end
    end

    // Command side: after each beat, stall for a random number of cycles
    initial
    begin : cmd_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (cmd_valid && !cmd_stall)
                hold = $urandom_range(0, stall_max);
            if (hold > 0)
            begin
                cmd_stall <= 1'b1;
                hold--;
            end
            else
                cmd_stall <= 1'b0;
        end
    end

    // One pose beat after a random gap; valid is left high on return
    task automatic send_pose(input int x, input int y, input int h);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            pose_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_valid   <= 1'b1;
        pose_x       <= POS_W'(x);
        pose_y       <= POS_W'(y);
        pose_heading <= HEAD_W'(h);
        do
            @(posedge clk);
        while (pose_stall);
    endtask

    // Stop sending and wait for every outstanding command beat
    task automatic wait_until_drained();
        pose_valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Full register set, with an unused index and junk above the gain fields
    task automatic set_controls(input int gx, input int gy, input int tol,
                                input int lg, input int ag);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ANG_GAIN) + 1, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom()));
        write_reg(CFG_GOAL_X, CFG_DATA_W'(gx));
        write_reg(CFG_GOAL_Y, CFG_DATA_W'(gy));
        write_reg(CFG_STOP_TOL, CFG_DATA_W'(tol));
        write_reg(CFG_LIN_GAIN, CFG_DATA_W'(lg) | (CFG_DATA_W'($urandom_range(0, 3)) << GAIN_W));
        write_reg(CFG_ANG_GAIN, CFG_DATA_W'(ag) | (CFG_DATA_W'($urandom_range(0, 3)) << GAIN_W));
        cfg_valid  <= 1'b0;
        goal_x_now = gx;
        goal_y_now = gy;
        tol_now    = tol;
    endtask

    function automatic int clip_pos(input int v);
        if (v < 0)
            return 0;
        if (v > POS_MAX)
            return POS_MAX;
        return v;
    endfunction

    // Mix of poses on the goal, near it and anywhere on the field
    task automatic send_random_pose();
        int x, y, h, kind, spread;
        kind   = $urandom_range(0, 9);
        spread = (tol_now < 500) ? tol_now + 8 : 512;
        if (kind == 0)
        begin
            x = goal_x_now;
            y = goal_y_now;
        end
        else if (kind <= 2)
        begin
            x = clip_pos(goal_x_now + int'($urandom_range(0, 2 * spread)) - spread);
            y = clip_pos(goal_y_now + int'($urandom_range(0, 2 * spread)) - spread);
        end
        else
        begin
            x = $urandom_range(0, POS_MAX);
            y = $urandom_range(0, POS_MAX);
        end
        if ($urandom_range(0, 9) == 0)
            h = int'($urandom_range(0, HEAD_MAX - HEAD_MIN)) + HEAD_MIN;
        else
            h = int'($urandom_range(0, 2 * HEADING_PI)) - HEADING_PI;
        send_pose(x, y, h);
        // now and then let the pipe run dry
        if ($urandom_range(0, 63) == 0)
            wait_until_drained();
    endtask

    initial
    begin : stimulus
        int mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed poses against the reset goal (1.0, 1.0), tolerance 10
        send_pose(GOAL_X_RST, GOAL_Y_RST, 0);              // on the goal
        send_pose(GOAL_X_RST + 10, GOAL_Y_RST, 0);         // distance equal to tolerance
        send_pose(GOAL_X_RST - 11, GOAL_Y_RST, 0);         // just outside
        send_pose(GOAL_X_RST + 6, GOAL_Y_RST + 8, 0);      // diagonal, on the tolerance
        send_pose(0, 0, 0);
        send_pose(POS_MAX, POS_MAX, 0);
        send_pose(0, POS_MAX, HEADING_PI);
        send_pose(POS_MAX, 0, -HEADING_PI);
        send_pose(2 * GOAL_X_RST, GOAL_Y_RST, 0);          // goal straight behind: +pi
        send_pose(2 * GOAL_X_RST, GOAL_Y_RST + 476, 0);    // behind and below
        send_pose(2 * GOAL_X_RST, GOAL_Y_RST - 524, 0);    // behind and above
        send_pose(GOAL_X_RST, 0, 0);                       // straight up
        send_pose(GOAL_X_RST, POS_MAX, 0);                 // straight down
        send_pose(500, 500, HEAD_MAX);                     // heading beyond pi
        send_pose(500, 500, HEAD_MIN);
        send_pose(3000, 200, 1);
        send_pose(0, GOAL_Y_RST, -1);

        // Random phases, each with its own register set and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_drained();
            case (p)
                0: ;
                1: set_controls(0, 0, 0, GAIN_MAX, GAIN_MAX);
                2: set_controls(POS_MAX, POS_MAX, TOL_MAX, 0, 0);
                3: set_controls(POS_MAX, 0, 0, GAIN_MAX, 1);
                default:
                    set_controls($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, TOL_MAX)
                                                             : $urandom_range(0, 200),
                                 $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX));
            endcase
            mode      = p % 4;
            gap_max   = (mode == 0 || mode == 3) ? 9 : 0;
            stall_max = (mode == 0 || mode == 2) ? 9 : 0;
            repeat (BEATS_PER_PHASE) send_random_pose();
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_cmds == 0)
            $display("go_to_goal_p_controller_top_tb OK");
        else
            $display("go_to_goal_p_controller_top_tb NOT OK");
        $finish;
    end

endmodule
